// ===== src/lpcd_pkg.sv =====
// Shared types and constants for the LRU page cache directory.
package lpcd_pkg;

    localparam int ENTRIES_DEF     = 16;
    localparam int TOTAL_PAGES_DEF = 4096;

    localparam int CAP_W  = 5;
    localparam int PAGE_W = 16;
    localparam int SLOT_W = 4;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    typedef enum logic
    {
        OP_ACCESS = 1'b0,
        OP_FLUSH  = 1'b1
    } lpcd_op_t;

    typedef enum logic [2:0]
    {
        ST_HIT        = 3'd0,
        ST_MISS       = 3'd1,
        ST_RANGE      = 3'd2,
        ST_FLUSH_WB   = 3'd3,
        ST_FLUSH_NONE = 3'd4
    } lpcd_status_t;

    typedef struct packed
    {
        lpcd_op_t            operation;
        logic [PAGE_W-1:0]   page_number;
    } lpcd_req_t;

    typedef struct packed
    {
        lpcd_status_t        status;
        logic [SLOT_W-1:0]   slot;
        logic [PAGE_W-1:0]   load_page;
        logic                writeback_valid;
        logic [PAGE_W-1:0]   writeback_page;
        logic                last;
    } lpcd_rsp_t;

    typedef struct packed
    {
        logic capture;
        logic access;
        logic flush_none;
        logic flush_step;
    } lpcd_cmd_t;

    typedef struct packed
    {
        logic req_flush;
        logic any_dirty;
        logic rank_dirty;
        logic flush_last;
        logic emit_ok;
    } lpcd_stat_t;

endpackage

// ===== src/lpcd_ctrl.sv =====
// Sequencing state machine for the LRU page cache directory.
module lpcd_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  lpcd_pkg::lpcd_stat_t stat,
    output lpcd_pkg::lpcd_cmd_t  cmd
);
    import lpcd_pkg::*;

    typedef enum logic [2:0]
    {
        S_IDLE  = 3'b001,
        S_EXEC  = 3'b010,
        S_FLUSH = 3'b100
    } lpcd_state_t;

    lpcd_state_t state_reg;
    lpcd_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (!stat.req_flush)
                begin
                    if (stat.emit_ok)
                    begin
                        cmd.access = 1'b1;
                        state_next = S_IDLE;
                    end
                end
                else if (!stat.any_dirty)
                begin
                    if (stat.emit_ok)
                    begin
                        cmd.flush_none = 1'b1;
                        state_next     = S_IDLE;
                    end
                end
                else
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (!stat.rank_dirty)
                begin
                    cmd.flush_step = 1'b1;
                end
                else if (stat.emit_ok)
                begin
                    cmd.flush_step = 1'b1;
                    if (stat.flush_last)
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== src/lpcd_dpath.sv =====
// Directory storage, tag compare, recency ranks and response register.
module lpcd_dpath
#(
    parameter int ENTRIES     = lpcd_pkg::ENTRIES_DEF,
    parameter int TOTAL_PAGES = lpcd_pkg::TOTAL_PAGES_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  lpcd_pkg::lpcd_req_t              req,
    input  logic                             cfg_we,
    input  logic [lpcd_pkg::CAP_W-1:0]       cfg_data,
    input  lpcd_pkg::lpcd_cmd_t              cmd,
    output lpcd_pkg::lpcd_stat_t             stat,
    input  logic                             rsp_ready,
    output logic                             rsp_valid,
    output lpcd_pkg::lpcd_rsp_t              rsp,
    output logic [$clog2(ENTRIES+1)-1:0]     count,
    output logic [ENTRIES-1:0]               valid_vec
);
    import lpcd_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam logic [PAGE_W:0] PAGE_LIMIT = (PAGE_W + 1)'(TOTAL_PAGES);

    lpcd_req_t          req_reg;
    logic [CAP_W-1:0]   cap_reg;
    logic [PAGE_W-1:0]  page_reg [ENTRIES];
    logic [ENTRIES-1:0] valid_reg, valid_next;
    logic [ENTRIES-1:0] dirty_reg, dirty_next;
    logic [IDX_W-1:0]   rank_reg [ENTRIES];
    logic [IDX_W-1:0]   rank_next [ENTRIES];
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]   fl_rank_reg, fl_rank_next;
    lpcd_rsp_t          rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic [ENTRIES-1:0] hit_vec, victim_vec, fl_vec, later_vec;
    logic               hit, oor, evict, emit_ok;
    logic [IDX_W-1:0]   hit_idx, hit_rank, victim_idx, free_idx, new_slot, fl_idx, rd_idx;
    logic [IDX_W-1:0]   lru_rank;
    logic [CNT_W-1:0]   eff_cap;
    logic [PAGE_W-1:0]  rd_page;
    logic               page_we;
    logic               rsp_load;

    assign emit_ok   = !rsp_valid_reg || rsp_ready;
    assign count     = count_reg;
    assign valid_vec = valid_reg;
    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        if (cap_reg == '0)
        begin
            eff_cap = CNT_W'(1);
        end
        else if (int'(cap_reg) > ENTRIES)
        begin
            eff_cap = CNT_W'(ENTRIES);
        end
        else
        begin
            eff_cap = CNT_W'(cap_reg);
        end
    end

    assign oor      = {1'b0, req_reg.page_number} >= PAGE_LIMIT;
    assign evict    = count_reg >= eff_cap;
    assign lru_rank = IDX_W'(count_reg - CNT_W'(1));

    // Parallel compares and encoders over all entries
    always_comb
    begin
        hit_idx    = '0;
        hit_rank   = '0;
        victim_idx = '0;
        fl_idx     = '0;
        free_idx   = '0;
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec[i]    = valid_reg[i] && (page_reg[i] == req_reg.page_number);
            victim_vec[i] = valid_reg[i] && (rank_reg[i] == lru_rank);
            fl_vec[i]     = valid_reg[i] && dirty_reg[i] && (rank_reg[i] == fl_rank_reg);
            later_vec[i]  = valid_reg[i] && dirty_reg[i] && (rank_reg[i] > fl_rank_reg);
            if (hit_vec[i])
            begin
                hit_idx  = hit_idx | IDX_W'(i);
                hit_rank = hit_rank | rank_reg[i];
            end
            if (victim_vec[i])
            begin
                victim_idx = victim_idx | IDX_W'(i);
            end
            if (fl_vec[i])
            begin
                fl_idx = fl_idx | IDX_W'(i);
            end
        end
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign hit      = |hit_vec;
    assign new_slot = evict ? victim_idx : free_idx;
    assign rd_idx   = (req_reg.operation == OP_FLUSH) ? fl_idx : victim_idx;
    assign rd_page  = page_reg[rd_idx];

    always_comb
    begin
        stat.req_flush  = (req_reg.operation == OP_FLUSH);
        stat.any_dirty  = |(valid_reg & dirty_reg);
        stat.rank_dirty = |fl_vec;
        stat.flush_last = !(|later_vec);
        stat.emit_ok    = emit_ok;
    end

    // State update and response build
    always_comb
    begin
        valid_next   = valid_reg;
        dirty_next   = dirty_reg;
        rank_next    = rank_reg;
        count_next   = count_reg;
        fl_rank_next = fl_rank_reg;
        page_we      = 1'b0;
        rsp_load     = 1'b0;
        rsp_next     = rsp_reg;

        if (cmd.capture)
        begin
            fl_rank_next = '0;
        end

        if (cmd.access)
        begin
            rsp_load = 1'b1;
            rsp_next = '0;
            rsp_next.last = 1'b1;
            if (oor)
            begin
                rsp_next.status = ST_RANGE;
            end
            else if (hit)
            begin
                rsp_next.status = ST_HIT;
                rsp_next.slot   = SLOT_W'(hit_idx);
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (hit_vec[i])
                    begin
                        rank_next[i] = '0;
                    end
                    else if (valid_reg[i] && (rank_reg[i] < hit_rank))
                    begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
            end
            else
            begin
                rsp_next.status          = ST_MISS;
                rsp_next.slot            = SLOT_W'(new_slot);
                rsp_next.load_page       = req_reg.page_number;
                rsp_next.writeback_valid = evict;
                rsp_next.writeback_page  = evict ? rd_page : '0;
                page_we                  = 1'b1;
                if (!evict)
                begin
                    count_next = count_reg + CNT_W'(1);
                end
                for (int i = 0; i < ENTRIES; i++)
                begin
                    if (IDX_W'(i) == new_slot)
                    begin
                        valid_next[i] = 1'b1;
                        dirty_next[i] = 1'b1;
                        rank_next[i]  = '0;
                    end
                    else if (valid_reg[i])
                    begin
                        rank_next[i] = rank_reg[i] + IDX_W'(1);
                    end
                end
            end
        end

        if (cmd.flush_none)
        begin
            rsp_load        = 1'b1;
            rsp_next        = '0;
            rsp_next.status = ST_FLUSH_NONE;
            rsp_next.last   = 1'b1;
        end

        if (cmd.flush_step)
        begin
            fl_rank_next = fl_rank_reg + IDX_W'(1);
            if (|fl_vec)
            begin
                dirty_next               = dirty_reg & ~fl_vec;
                rsp_load                 = 1'b1;
                rsp_next                 = '0;
                rsp_next.status          = ST_FLUSH_WB;
                rsp_next.slot            = SLOT_W'(fl_idx);
                rsp_next.writeback_valid = 1'b1;
                rsp_next.writeback_page  = rd_page;
                rsp_next.last            = !(|later_vec);
            end
        end

        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RESET;
            valid_reg     <= '0;
            dirty_reg     <= '0;
            count_reg     <= '0;
            fl_rank_reg   <= '0;
            rsp_valid_reg <= 1'b0;
            for (int i = 0; i < ENTRIES; i++)
            begin
                rank_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                cap_reg <= cfg_data;
            end
            valid_reg     <= valid_next;
            dirty_reg     <= dirty_next;
            count_reg     <= count_next;
            fl_rank_reg   <= fl_rank_next;
            rsp_valid_reg <= rsp_valid_next;
            rank_reg      <= rank_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg <= req;
        end
        if (page_we)
        begin
            page_reg[new_slot] <= req_reg.page_number;
        end
        if (rsp_load)
        begin
            rsp_reg <= rsp_next;
        end
    end

endmodule

// ===== src/lru_page_cache_directory_top.sv =====
// Top level of the LRU page cache directory: controller, datapath and checks.
//
// Fully associative page directory with least-recently-used replacement. One
// request is handled at a time. An access passes from the accept state to an
// execute state that does the parallel tag compare and recency update over all
// entries. A flush instead steps, after the execute state, through the recency
// ranks one at a time up to the last dirty page, with one writeback response per
// dirty page; the single response register can stall either when rsp_ready is
// low. The response register lets a new request be accepted while the last
// response is still waiting. No clearing pass is needed after reset.
module lru_page_cache_directory_top
#(
    parameter int ENTRIES     = lpcd_pkg::ENTRIES_DEF,
    parameter int TOTAL_PAGES = lpcd_pkg::TOTAL_PAGES_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  lpcd_pkg::lpcd_req_t        req,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output lpcd_pkg::lpcd_rsp_t        rsp,
    input  logic                       cfg_we,
    input  logic [lpcd_pkg::CAP_W-1:0] cfg_data
);
    import lpcd_pkg::*;

    localparam int CNT_W = $clog2(ENTRIES + 1);

    lpcd_cmd_t          cmd;
    lpcd_stat_t         stat;
    logic [CNT_W-1:0]   count;
    logic [ENTRIES-1:0] valid_vec;

    lpcd_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    lpcd_dpath
    #(
        .ENTRIES     (ENTRIES),
        .TOTAL_PAGES (TOTAL_PAGES)
    )
    u_dpath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .stat      (stat),
        .rsp_ready (rsp_ready),
        .rsp_valid (rsp_valid),
        .rsp       (rsp),
        .count     (count),
        .valid_vec (valid_vec)
    );

`ifndef NO_ASSERTIONS
    a_one_request: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> !req_ready)
        else $error("request accepted while previous request in progress");

    a_count_match: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(valid_vec) == int'(count))
        else $error("resident count disagrees with valid entries");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(count) <= ENTRIES)
        else $error("resident count above entry count");

    a_miss_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.status == ST_MISS) |->
            ({1'b0, rsp.load_page} < (PAGE_W + 1)'(TOTAL_PAGES)))
        else $error("miss loads a page past the file size");
`endif

endmodule

// ===== dv/lru_page_cache_directory_top_test.sv =====
// Self-checking testbench for the LRU page cache directory: directory shadow model, random traffic.
module lru_page_cache_directory_top_test;
    import lpcd_pkg::*;

    localparam int ENTRIES     = ENTRIES_DEF;
    localparam int TOTAL_PAGES = TOTAL_PAGES_DEF;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               req_valid = 1'b0;
    logic               req_ready;
    lpcd_req_t          req       = '0;
    logic               rsp_valid;
    logic               rsp_ready = 1'b0;
    lpcd_rsp_t          rsp;
    logic               cfg_we    = 1'b0;
    logic [CAP_W-1:0]   cfg_data  = CAP_RESET;

    // shadow copy of the directory
    logic [PAGE_W-1:0]  dir_page  [ENTRIES];
    logic               dir_valid [ENTRIES] = '{default: 1'b0};
    logic               dir_dirty [ENTRIES] = '{default: 1'b0};
    logic [SLOT_W-1:0]  dir_rank  [ENTRIES] = '{default: '0};
    int unsigned        resident  = 0;
    logic [CAP_W-1:0]   capacity  = CAP_RESET;

    lpcd_rsp_t          due_responses[$];
    lpcd_rsp_t          want;
    int unsigned        mismatch_count = 0;
    bit                 src_gaps  = 1'b1;
    logic               sink_gaps = 1'b1;
    logic               sink_hold = 1'b0;

    lru_page_cache_directory_top
    #(
        .ENTRIES     (ENTRIES),
        .TOTAL_PAGES (TOTAL_PAGES)
    )
    u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic void predict_directory(input lpcd_req_t item);
        lpcd_rsp_t          r;
        int                 found;
        int unsigned        dirty_total;
        int unsigned        sent;
        int unsigned        limit;
        logic [SLOT_W-1:0]  worst;
        found = -1;
        r = '0;
        if (item.operation == OP_FLUSH)
        begin
            dirty_total = 0;
            sent = 0;
            for (int i = 0; i < ENTRIES; i++)
                if (dir_valid[i] && dir_dirty[i])
                    dirty_total++;
            if (dirty_total == 0)
            begin
                r.status = ST_FLUSH_NONE;
                r.last   = 1'b1;
                due_responses.push_back(r);
                return;
            end
            for (int k = 0; k < resident; k++)
                for (int i = 0; i < ENTRIES; i++)
                    if (dir_valid[i] && dir_dirty[i] && dir_rank[i] == k)
                    begin
                        sent++;
                        r = '0;
                        r.status          = ST_FLUSH_WB;
                        r.slot            = SLOT_W'(i);
                        r.writeback_valid = 1'b1;
                        r.writeback_page  = dir_page[i];
                        r.last            = (sent == dirty_total);
                        due_responses.push_back(r);
                        dir_dirty[i] = 1'b0;
                    end
            return;
        end
        if (item.page_number >= TOTAL_PAGES)
        begin
            r.status = ST_RANGE;
            r.last   = 1'b1;
            due_responses.push_back(r);
            return;
        end
        for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && dir_valid[i] && dir_page[i] == item.page_number)
                found = i;
        if (found >= 0)
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (dir_valid[i] && dir_rank[i] < dir_rank[found])
                    dir_rank[i]++;
            dir_rank[found] = '0;
            r.status = ST_HIT;
            r.slot   = SLOT_W'(found);
            r.last   = 1'b1;
            due_responses.push_back(r);
            return;
        end
        // miss: zero capacity acts as one, oversize acts as full
        limit = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : capacity);
        worst = '0;
        if (resident >= limit)
        begin
            for (int i = 0; i < ENTRIES; i++)
                if (dir_valid[i] && (found < 0 || dir_rank[i] > worst))
                begin
                    found = i;
                    worst = dir_rank[i];
                end
            if (found >= 0)
            begin
                r.writeback_valid = 1'b1;
                r.writeback_page  = dir_page[found];
                dir_valid[found]  = 1'b0;
                resident--;
            end
        end
        for (int i = 0; i < ENTRIES; i++)
            if (found < 0 && !dir_valid[i])
                found = i;
        for (int i = 0; i < ENTRIES; i++)
            if (dir_valid[i])
                dir_rank[i]++;
        dir_valid[found] = 1'b1;
        dir_dirty[found] = 1'b1;
        dir_page[found]  = item.page_number;
        dir_rank[found]  = '0;
        resident++;
        r.status    = ST_MISS;
        r.slot      = SLOT_W'(found);
        r.load_page = item.page_number;
        r.last      = 1'b1;
        due_responses.push_back(r);
    endfunction

    task automatic send_request(input lpcd_op_t op, input logic [PAGE_W-1:0] page);
        int unsigned gap;
        lpcd_req_t   item;
        gap = src_gaps ? $urandom_range(0, 14) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item.operation   = op;
        item.page_number = page;
        predict_directory(item);
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        while (due_responses.size() != 0)
            @(posedge clk);
        repeat (ENTRIES + 8) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] value);
        cfg_data <= value;
        cfg_we   <= 1'b1;
        @(posedge clk);
        cfg_we   <= 1'b0;
        capacity = value;
    endtask

    task automatic test_basic_access();
        send_request(OP_FLUSH, 16'hFFFF);
        send_request(OP_ACCESS, 16'd0);
        send_request(OP_ACCESS, 16'(TOTAL_PAGES - 1));
        send_request(OP_ACCESS, 16'(TOTAL_PAGES));
        send_request(OP_ACCESS, 16'hFFFF);
        send_request(OP_ACCESS, 16'd0);
        send_request(OP_ACCESS, 16'h0AAA);
        send_request(OP_ACCESS, 16'h0555);
        send_request(OP_FLUSH, 16'h0000);
        send_request(OP_FLUSH, 16'h8001);
        send_request(OP_ACCESS, 16'h0AAA);
    endtask

    task automatic test_eviction();
        wait_idle();
        write_capacity(5'd2);
        send_request(OP_ACCESS, 16'd100);
        send_request(OP_ACCESS, 16'd200);
        send_request(OP_ACCESS, 16'd100);
        send_request(OP_ACCESS, 16'd300);
        send_request(OP_ACCESS, 16'd200);
        send_request(OP_FLUSH, 16'd0);
        // shrink below the resident count
        wait_idle();
        write_capacity(5'd1);
        send_request(OP_ACCESS, 16'd400);
        send_request(OP_ACCESS, 16'd500);
        send_request(OP_FLUSH, 16'd0);
        wait_idle();
        write_capacity(5'd0);
        send_request(OP_ACCESS, 16'd7);
        send_request(OP_ACCESS, 16'd8);
        send_request(OP_ACCESS, 16'd7);
        wait_idle();
        write_capacity(5'd31);
        send_request(OP_ACCESS, 16'd9);
    endtask

    task automatic run_traffic(input logic [CAP_W-1:0] cap_value, input int mode,
                               input int unsigned count);
        int unsigned      roll;
        int unsigned      span;
        logic [PAGE_W-1:0] base;
        wait_idle();
        write_capacity(cap_value);
        src_gaps  = (mode == 1 || mode == 2);
        sink_gaps <= (mode == 1 || mode == 3);
        span = (cap_value == 0) ? 2 : ((cap_value > ENTRIES) ? 22 : cap_value + cap_value / 2 + 1);
        base = PAGE_W'($urandom_range(0, TOTAL_PAGES - 32));
        repeat (count)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 62)
                send_request(OP_ACCESS, PAGE_W'(base + $urandom_range(0, span)));
            else if (roll < 74)
                send_request(OP_ACCESS, PAGE_W'($urandom_range(0, TOTAL_PAGES - 1)));
            else if (roll < 84)
                send_request(OP_ACCESS, PAGE_W'($urandom_range(0, 65535)));
            else if (roll < 88)
                send_request(OP_ACCESS,
                             PAGE_W'($urandom_range(TOTAL_PAGES - 4, TOTAL_PAGES + 3)));
            else
                send_request(OP_FLUSH, PAGE_W'($urandom_range(0, 65535)));
        end
    endtask

    task automatic test_random_traffic();
        run_traffic(5'd16, 0, 47);
        run_traffic(5'd1, 1, 47);
        run_traffic(5'd4, 2, 47);
        run_traffic(5'd31, 3, 47);
        run_traffic(5'd0, 1, 47);
        run_traffic(5'd9, 0, 47);
        run_traffic(5'd17, 3, 47);
        run_traffic(CAP_W'($urandom_range(1, ENTRIES)), 1, 47);
    endtask

    task automatic test_output_stall();
        wait_idle();
        src_gaps = 1'b0;
        fork
            begin
                sink_hold <= 1'b1;
                repeat (300) @(posedge clk);
                sink_hold <= 1'b0;
            end
            begin
                for (int n = 0; n < 24; n++)
                    if (n % 6 == 5)
                        send_request(OP_FLUSH, PAGE_W'($urandom_range(0, 65535)));
                    else
                        send_request(OP_ACCESS, PAGE_W'($urandom_range(0, 40)));
            end
        join
        wait_idle();
    endtask

    initial
    begin : response_sink
        int unsigned stall;
        stall = 0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (rsp_valid && rsp_ready)
                stall = sink_gaps ? $urandom_range(0, 14) : 0;
            else if (stall > 0)
                stall--;
            rsp_ready <= !sink_hold && stall == 0;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (due_responses.size() == 0)
            begin
                $error("unexpected response: status %0d slot %0d", rsp.status, rsp.slot);
                mismatch_count++;
            end
            else
            begin
                want = due_responses.pop_front();
                if (rsp.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, rsp.status);
                    mismatch_count++;
                end
                if (rsp.slot !== want.slot)
                begin
                    $error("slot: expected %0d, got %0d", want.slot, rsp.slot);
                    mismatch_count++;
                end
                if (rsp.load_page !== want.load_page)
                begin
                    $error("load_page: expected %0d, got %0d", want.load_page, rsp.load_page);
                    mismatch_count++;
                end
                if (rsp.writeback_valid !== want.writeback_valid)
                begin
                    $error("writeback_valid: expected %0d, got %0d",
                           want.writeback_valid, rsp.writeback_valid);
                    mismatch_count++;
                end
                if (rsp.writeback_page !== want.writeback_page)
                begin
                    $error("writeback_page: expected %0d, got %0d",
                           want.writeback_page, rsp.writeback_page);
                    mismatch_count++;
                end
                if (rsp.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, rsp.last);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_access();
        test_eviction();
        test_random_traffic();
        test_output_stall();
        wait_idle();
        if (mismatch_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #(5000000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
